/* src/sem_pkg.sv */
package sem_pkg;

    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int PIX_W           = 8;
    localparam int DIM_W           = 12;
    localparam int ROW_W           = 13;
    localparam int REG_IDX_W       = 2;
    localparam int WIDTH_RESET     = 640;
    localparam int HEIGHT_RESET    = 480;
    localparam int EDGE_MAX        = 255;
    localparam int DIM_MIN         = 2;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef logic [PIX_W-1:0] t_pix;

    // one window column, element 0 is the oldest row
    typedef t_pix [2:0] t_col;

    // per-word control carried in the read stage
    typedef struct packed {
        t_pix pixel;
        logic col_first;
        logic col_ge2;
        logic row1_ok;
        logic row2_ok;
        logic last;
    } t_stage;

endpackage

/* src/sem_ifs.sv */
interface sem_cfg_if import sem_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] reg_index;
    logic [DIM_W-1:0]     reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

interface sem_pix_if import sem_pkg::*; ;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic       drain;

    modport source (output valid, pixel_value, drain, input ready);
    modport sink   (input valid, pixel_value, drain, output ready);
endinterface

interface sem_edge_if import sem_pkg::*; ;
    logic       valid;
    logic       ready;
    logic [7:0] edge_value;
    logic       frame_end;

    modport source (output valid, edge_value, frame_end, input ready);
    modport sink   (input valid, edge_value, frame_end, output ready);
endinterface

/* src/sem_ram.sv */
module sem_ram import sem_pkg::*; #(
    parameter int WIDTH = 16,
    parameter int DEPTH = MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/sem_grad.sv */
module sem_grad import sem_pkg::*; (
    input  t_col i_left,
    input  t_col i_mid,
    input  t_col i_right,
    output t_pix o_edge
);

    logic [9:0]         l_col_sum, r_col_sum, top_sum, bot_sum;
    logic signed [10:0] gx, gy;
    logic [9:0]         ax, ay;
    logic [10:0]        mag;

    always_comb begin
        l_col_sum = 10'(i_left[0])  + {1'b0, i_left[1], 1'b0}  + 10'(i_left[2]);
        r_col_sum = 10'(i_right[0]) + {1'b0, i_right[1], 1'b0} + 10'(i_right[2]);
        bot_sum   = 10'(i_left[2])  + {1'b0, i_mid[2], 1'b0}   + 10'(i_right[2]);
        top_sum   = 10'(i_left[0])  + {1'b0, i_mid[0], 1'b0}   + 10'(i_right[0]);
        gx = signed'({1'b0, l_col_sum}) - signed'({1'b0, r_col_sum});
        gy = signed'({1'b0, bot_sum})   - signed'({1'b0, top_sum});
        ax = gx[10] ? 10'(-gx) : gx[9:0];
        ay = gy[10] ? 10'(-gy) : gy[9:0];
        mag = 11'(ax) + 11'(ay);
        o_edge = (mag > 11'(EDGE_MAX)) ? t_pix'(EDGE_MAX) : mag[7:0];
    end

endmodule

/* src/sobel_edge_magnitude.sv */
// Channel   Dir  Word                          Notes
// i_cfg     in   reg_index, reg_data (12b)     0 = image width, 1 = image height
// i_pix     in   pixel_value (8b), drain       raster order, W+1 drains per frame
// o_edge    out  edge_value (8b), frame_end    one word per image position
//
// One input word per clock sustained while o_edge is not stalled; a result passes
// the line-store read stage, then the gradient and output register.
// The line store is one dual-port RAM holding both previous rows per column.
// Synchronous active-low reset restores 640x480 and restarts the scan; the
// line store is not cleared. A width or height write also restarts the scan.
// A stall on o_edge backs up through the read stage to i_pix.ready.
module sobel_edge_magnitude import sem_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sem_cfg_if.sink i_cfg,
    sem_pix_if.sink i_pix,
    sem_edge_if.source o_edge
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int LW = (CW > DIM_W) ? CW : DIM_W;

    logic [DIM_W-1:0] r_width, r_height;
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    logic             r_s1_valid;
    t_stage           r_s1;
    logic [AW-1:0]    r_s1_addr;

    t_col             r_win_l, r_win_m;

    logic             r_out_valid;
    t_pix             r_out_edge;
    logic             r_out_last;

    logic [CW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             pix_acc, cfg_acc, s1_adv, produce;
    logic             col_wrap, acc_last;
    t_stage           n_s1;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic [15:0]      rd_word, wr_word;
    t_col             newcol, g_left, g_right;
    t_pix             edge_val;

    // effective frame size
    always_comb begin
        if (r_width < DIM_W'(DIM_MIN)) begin
            w_eff = CW'(DIM_MIN);
        end else if (LW'(r_width) > LW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_width);
        end
        h_eff = (r_height < DIM_W'(DIM_MIN)) ? ROW_W'(DIM_MIN) : ROW_W'(r_height);
    end

    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !r_s1_valid || s1_adv;

    // scan position of the word being accepted, and where it goes next
    always_comb begin
        n_s1.col_first = (r_col == '0);
        n_s1.col_ge2   = (r_col >= AW'(2));
        n_s1.row1_ok   = (r_row != '0) && (r_row <= h_eff);
        n_s1.row2_ok   = (r_row >= ROW_W'(2)) && (r_row <= h_eff + ROW_W'(1));
        acc_last       = n_s1.col_first && (r_row == h_eff + ROW_W'(1));
        n_s1.last      = acc_last;
        n_s1.pixel     = (!i_pix.drain && (r_row < h_eff)) ? i_pix.pixel_value : '0;
        col_wrap       = (CW'(r_col) + CW'(1)) >= w_eff;

        n_col = r_col;
        n_row = r_row;
        if (acc_last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_wrap) begin
            n_col = '0;
            n_row = (r_row < h_eff + ROW_W'(1)) ? r_row + ROW_W'(1) : '0;
        end else begin
            n_col = r_col + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(WIDTH_RESET);
            r_height <= DIM_W'(HEIGHT_RESET);
            r_col    <= '0;
            r_row    <= '0;
        end else if (cfg_acc) begin
            if (i_cfg.reg_index == REG_IMAGE_WIDTH) begin
                r_width <= i_cfg.reg_data;
                r_col   <= '0;
                r_row   <= '0;
            end else if (i_cfg.reg_index == REG_IMAGE_HEIGHT) begin
                r_height <= i_cfg.reg_data;
                r_col    <= '0;
                r_row    <= '0;
            end
        end else if (pix_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store: [15:8] row r-2, [7:0] row r-1
    sem_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_word),
        .i_re    (pix_acc),
        .i_raddr (r_col),
        .o_rdata (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pix_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1      <= n_s1;
            r_s1_addr <= r_col;
        end
    end

    // gradient stage
    always_comb begin
        newcol[0] = r_s1.row2_ok ? rd_word[15:8] : '0;
        newcol[1] = r_s1.row1_ok ? rd_word[7:0]  : '0;
        newcol[2] = r_s1.pixel;
        wr_word   = {newcol[1], newcol[2]};
        g_left    = (!r_s1.col_first && !r_s1.col_ge2) ? '0 : r_win_l;
        g_right   = r_s1.col_first ? '0 : newcol;
        produce   = r_s1.col_first ? r_s1.row2_ok : r_s1.row1_ok;
        s1_adv    = r_s1_valid && (!produce || !r_out_valid || o_edge.ready);
    end

    sem_grad u_grad (
        .i_left  (g_left),
        .i_mid   (r_win_m),
        .i_right (g_right),
        .o_edge  (edge_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_l <= '0;
            r_win_m <= '0;
        end else if (s1_adv) begin
            r_win_l <= r_win_m;
            r_win_m <= newcol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && produce) begin
            r_out_valid <= 1'b1;
        end else if (o_edge.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && produce) begin
            r_out_edge <= edge_val;
            r_out_last <= r_s1.col_first && r_s1.last;
        end
    end

    assign o_edge.valid      = r_out_valid;
    assign o_edge.edge_value = r_out_edge;
    assign o_edge.frame_end  = r_out_last;

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_col) < w_eff)
        else $error("scan column beyond row width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cfg_acc |=> r_row <= h_eff + ROW_W'(1))
        else $error("scan row beyond drain rows");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_acc && !cfg_acc && acc_last) |=> (r_col == '0 && r_row == '0))
        else $error("scan did not restart after last word of frame");

    a_last_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.last) |-> (r_s1.col_first && r_s1.row2_ok))
        else $error("frame end outside a right-edge result");

endmodule

/* tb/sv/tb_sobel_edge_magnitude.sv */
module tb_sobel_edge_magnitude import sem_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RAND_WORDS    = 640;
    localparam int          DIR_ROWS      = 28;

    // indexes with no register behind them
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam t_col BLANK_COL = '0;

    typedef enum logic {ROW_REG, ROW_WORD} t_row_kind;
    typedef enum logic [1:0] {PIX_NOISE, PIX_LOW, PIX_RAMP, PIX_FLAT} t_pix_mode;
    typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SPARSE} t_sink_mode;

    typedef struct packed {
        t_row_kind            kind;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [DIM_W-1:0]     reg_data;
        t_pix                 pixel;
        logic                 drain;
        logic                 typed;
        t_pix                 t_mag;
        logic                 t_last;
    } t_dir_row;

    typedef struct {
        t_pix mag;
        logic last;
    } t_edge_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sem_cfg_if  cfg_bus ();
    sem_pix_if  pix_bus ();
    sem_edge_if edge_bus ();

    sobel_edge_magnitude #(.MAX_WIDTH(MAX_WIDTH_DEF)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_edge  (edge_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // own copy of the block state
    logic [DIM_W-1:0] img_width;
    logic [DIM_W-1:0] img_height;
    t_pix             line_prev  [MAX_WIDTH_DEF];
    t_pix             line_prev2 [MAX_WIDTH_DEF];
    t_col             win_old;
    t_col             win_mid;
    int unsigned      scan_x;
    int unsigned      scan_y;

    t_edge_word  pending_edges [$];
    t_edge_word  head_word;
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned holds_asked = 0;
    int unsigned holds_done  = 0;

    // register fields are unused on word rows
    t_dir_row dir_table [DIR_ROWS] = '{
        // width and height below range, both act as 2
        '{ROW_REG,  REG_IMAGE_WIDTH,  12'd1, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_REG,  REG_IMAGE_HEIGHT, 12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        // full-scale frame: zero padding makes every position saturate
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1'b1, 1'b1, 8'd255, 1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1'b1, 1'b1, 8'd255, 1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1'b1, 1'b1, 8'd255, 1'b1},
        // dark frame: early drain and late pixels carry 255 but count as zero
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1'b1, 1'b1, 8'd0,   1'b1},
        // partial frame, then a write restarts the scan mid-frame
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd10,  1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd200, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd37,  1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd90,  1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_REG,  REG_IMAGE_WIDTH,  12'd3, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_REG,  REG_IMAGE_HEIGHT, 12'd3, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd128, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd1,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd254, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, REG_IMAGE_WIDTH,  12'd0, 8'd77,  1'b0, 1'b0, 8'd0,   1'b0}
    };

    function automatic int unsigned active_width(input logic [DIM_W-1:0] v);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return v;
    endfunction

    function automatic int unsigned active_height(input logic [DIM_W-1:0] v);
        return (v < DIM_MIN) ? DIM_MIN : v;
    endfunction

    // column element 0 is the top row of the window
    function automatic t_pix sobel_mag(input t_col lft, input t_col mid, input t_col rgt);
        int gx;
        int gy;
        int s;
        gx = (int'(lft[0]) + 2 * int'(lft[1]) + int'(lft[2]))
           - (int'(rgt[0]) + 2 * int'(rgt[1]) + int'(rgt[2]));
        gy = (int'(lft[2]) + 2 * int'(mid[2]) + int'(rgt[2]))
           - (int'(lft[0]) + 2 * int'(mid[0]) + int'(rgt[0]));
        s = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
        return (s > EDGE_MAX) ? t_pix'(EDGE_MAX) : t_pix'(s);
    endfunction

    function automatic bit advance_scan(input t_pix p, input logic d,
                                        output t_pix mag, output logic last);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        t_col        nc;
        bit          got;
        w    = active_width(img_width);
        h    = active_height(img_height);
        col  = scan_x;
        row  = scan_y;
        got  = 1'b0;
        last = 1'b0;
        mag  = '0;
        if (col >= w) col = w - 1;
        nc[0] = (row >= 2 && row - 2 < h) ? line_prev2[col] : '0;
        nc[1] = (row >= 1 && row - 1 < h) ? line_prev[col] : '0;
        nc[2] = (!d && row < h) ? p : '0;
        if (col >= 1) begin
            // centre one column back, one row up; left padded at column 1
            if (row >= 1 && row - 1 < h) begin
                mag = sobel_mag((col >= 2) ? win_old : BLANK_COL, win_mid, nc);
                got = 1'b1;
            end
        end else if (row >= 2 && row - 2 < h) begin
            // last column of the row two up, right side padded
            mag  = sobel_mag(win_old, win_mid, BLANK_COL);
            last = (row - 2 == h - 1);
            got  = 1'b1;
        end
        line_prev2[col] = nc[1];
        line_prev[col]  = nc[2];
        win_old = win_mid;
        win_mid = nc;
        if (last) begin
            scan_x = 0;
            scan_y = 0;
        end else if (col + 1 >= w) begin
            scan_x = 0;
            scan_y = (row < h + 1) ? row + 1 : 0;
        end else begin
            scan_x = col + 1;
        end
        return got;
    endfunction

    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no gap
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.reg_data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        case (idx)
            REG_IMAGE_WIDTH: begin
                img_width = data;
                scan_x = 0;
                scan_y = 0;
            end
            REG_IMAGE_HEIGHT: begin
                img_height = data;
                scan_x = 0;
                scan_y = 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input t_pix p, input logic d, input logic typed,
                             input t_pix t_mag, input logic t_last);
        int unsigned gap;
        bit          got;
        t_pix        mag;
        logic        last;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                pix_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel_value <= p;
        pix_bus.drain       <= d;
        @(posedge i_clk);
        while (!pix_bus.ready) @(posedge i_clk);
        got = advance_scan(p, d, mag, last);
        if (typed) begin
            if (!got) begin
                $display("%0t: table row expects an edge word, none predicted", $time);
                fault_count++;
            end else begin
                pending_edges.push_back('{t_mag, t_last});
            end
        end else if (got) begin
            pending_edges.push_back('{mag, last});
        end
    endtask

    // one frame of w*h pixels and w+1 drains; cut stops it early, messy
    // sprinkles early drains and late pixels
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input int unsigned cut, input bit messy,
                              output int unsigned sent);
        t_pix_mode   mode;
        int unsigned sx;
        int unsigned sy;
        int unsigned base;
        int unsigned total;
        t_pix        p;
        logic        d;
        mode  = t_pix_mode'($urandom_range(0, 3));
        sx    = $urandom_range(0, 40);
        sy    = $urandom_range(0, 40);
        base  = $urandom_range(0, 255);
        total = w * h + w + 1;
        if (cut != 0 && cut < total) total = cut;
        sent = 0;
        for (int unsigned k = 0; k < total; k++) begin
            if (k < w * h) begin
                case (mode)
                    PIX_NOISE: p = t_pix'($urandom_range(0, 255));
                    PIX_LOW:   p = t_pix'($urandom_range(0, 24));
                    PIX_RAMP:  p = t_pix'(base + (k % w) * sx + (k / w) * sy);
                    default:   p = t_pix'(base);
                endcase
                d = messy && ($urandom_range(0, 7) == 0);
            end else begin
                p = t_pix'($urandom_range(0, 255));
                d = !(messy && ($urandom_range(0, 2) == 0));
            end
            send_word(p, d, 1'b0, '0, 1'b0);
            sent++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && edge_bus.valid && edge_bus.ready) begin
            if (pending_edges.size() == 0) begin
                $display("%0t: unexpected edge word: got edge=%0d last=%0b",
                         $time, edge_bus.edge_value, edge_bus.frame_end);
                fault_count++;
            end else begin
                head_word = pending_edges.pop_front();
                if (edge_bus.edge_value !== head_word.mag ||
                    edge_bus.frame_end !== head_word.last) begin
                    $display("%0t: edge mismatch: exp edge=%0d last=%0b, got edge=%0d last=%0b",
                             $time, head_word.mag, head_word.last,
                             edge_bus.edge_value, edge_bus.frame_end);
                    fault_count++;
                end
            end
        end
    end

    // receiver back-pressure, with a long hold-off on request
    initial begin
        t_sink_mode  mode;
        int unsigned stretch;
        int unsigned period;
        int unsigned tick;
        mode    = SINK_OPEN;
        stretch = 0;
        period  = 2;
        tick    = 0;
        forever begin
            if (holds_asked > holds_done) begin
                holds_done++;
                edge_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (stretch == 0) begin
                    mode    = t_sink_mode'($urandom_range(0, 3));
                    stretch = $urandom_range(10, 200);
                    period  = $urandom_range(2, 5);
                end
                stretch--;
                tick++;
                case (mode)
                    SINK_OPEN:     edge_bus.ready <= 1'b1;
                    SINK_RANDOM:   edge_bus.ready <= ($urandom_range(0, 3) != 0);
                    SINK_PERIODIC: edge_bus.ready <= ((tick % period) != 0);
                    default:       edge_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        int unsigned      rand_words;
        int unsigned      phase_no;
        int unsigned      nframes;
        int unsigned      n;
        int unsigned      cut;
        int unsigned      w_eff;
        int unsigned      h_eff;
        logic [DIM_W-1:0] w_reg;
        logic [DIM_W-1:0] h_reg;

        i_rst_n             <= 1'b0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.reg_index   <= REG_IMAGE_WIDTH;
        cfg_bus.reg_data    <= '0;
        pix_bus.valid       <= 1'b0;
        pix_bus.pixel_value <= '0;
        pix_bus.drain       <= 1'b0;

        img_width  = DIM_W'(WIDTH_RESET);
        img_height = DIM_W'(HEIGHT_RESET);
        for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
            line_prev[i]  = '0;
            line_prev2[i] = '0;
        end
        win_old = '0;
        win_mid = '0;
        scan_x  = 0;
        scan_y  = 0;
        w_reg   = DIM_W'(WIDTH_RESET);
        h_reg   = DIM_W'(HEIGHT_RESET);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_table[i].kind == ROW_REG) begin
                if (i == 0 || dir_table[i-1].kind != ROW_REG) wait_idle();
                write_reg(dir_table[i].reg_idx, dir_table[i].reg_data);
                if (i == DIR_ROWS - 1 || dir_table[i+1].kind != ROW_REG) cfg_bus.valid <= 1'b0;
            end else begin
                send_word(dir_table[i].pixel, dir_table[i].drain, dir_table[i].typed,
                          dir_table[i].t_mag, dir_table[i].t_last);
            end
        end
        w_reg = 12'd3;
        h_reg = 12'd3;

        rand_words = 0;
        phase_no   = 0;
        while (rand_words < RAND_WORDS) begin
            wait_idle();
            // a write to a spare index changes nothing, not even the scan
            if ($urandom_range(0, 5) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                          DIM_W'($urandom));
            case (phase_no)
                4: begin
                    // width far past the line store, clamps to its size
                    w_reg = '1;
                    h_reg = 12'd2;
                    write_reg(REG_IMAGE_WIDTH, w_reg);
                    write_reg(REG_IMAGE_HEIGHT, h_reg);
                end
                7: begin
                    w_reg = 12'd3;
                    h_reg = '1;
                    write_reg(REG_IMAGE_WIDTH, w_reg);
                    write_reg(REG_IMAGE_HEIGHT, h_reg);
                end
                default: begin
                    if ($urandom_range(0, 4) != 0) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4, 5, 6: w_reg = DIM_W'($urandom_range(2, 8));
                            7:                   w_reg = DIM_W'($urandom_range(0, 1));
                            default:             w_reg = DIM_W'($urandom_range(9, 40));
                        endcase
                        write_reg(REG_IMAGE_WIDTH, w_reg);
                    end
                    if ($urandom_range(0, 4) != 0) begin
                        h_reg = ($urandom_range(0, 4) == 0) ? DIM_W'($urandom_range(0, 1))
                                                            : DIM_W'($urandom_range(2, 6));
                        write_reg(REG_IMAGE_HEIGHT, h_reg);
                    end
                end
            endcase
            cfg_bus.valid <= 1'b0;
            w_eff = active_width(w_reg);
            h_eff = active_height(h_reg);

            if (phase_no == 4) begin
                send_frame(w_eff, h_eff, 64, 1'b0, n);
                rand_words += n;
            end else if (phase_no == 7) begin
                send_frame(w_eff, h_eff, 120, 1'b0, n);
                rand_words += n;
            end else begin
                if (phase_no == 2 || phase_no == 11) holds_asked++;
                nframes = $urandom_range(1, 3);
                for (int unsigned f = 0; f < nframes; f++) begin
                    cut = 0;
                    if (f == nframes - 1 && $urandom_range(0, 5) == 0)
                        cut = $urandom_range(1, w_eff * h_eff + w_eff);
                    send_frame(w_eff, h_eff, cut, ($urandom_range(0, 4) == 0), n);
                    rand_words += n;
                end
                // stray words with random drain flags
                if ($urandom_range(0, 7) == 0) begin
                    n = $urandom_range(1, 16);
                    for (int unsigned k = 0; k < n; k++)
                        send_word(t_pix'($urandom_range(0, 255)), logic'($urandom_range(0, 1)),
                                  1'b0, '0, 1'b0);
                    rand_words += n;
                end
            end
            phase_no++;
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fault_count == 0 && pending_edges.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
src/sem_pkg.sv
src/sem_ifs.sv
src/sem_ram.sv
src/sem_grad.sv
src/sobel_edge_magnitude.sv
tb/sv/tb_sobel_edge_magnitude.sv
